// ===== rtl/core/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types and constants of the serial frame receiver
// ----------------------------------------------------------------------------
package sfr_pkg;

  // total frame bytes beyond the payload: start, type, length, checksum, end
  localparam logic [8:0] FRAME_OVERHEAD = 9'd5;

  localparam logic [7:0] IDLE_TICKS_MAX = 8'hff;

  // register reset values
  localparam logic [7:0] START_BYTE_RST      = 8'd170;
  localparam logic [7:0] TYPE_BYTE_RST       = 8'd81;
  localparam logic [7:0] END_BYTE_RST        = 8'd85;
  localparam logic [8:0] MAX_FRAME_BYTES_RST = 9'd64;
  localparam logic [7:0] IDLE_LIMIT_RST      = 8'd50;

  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_BYTE      = 3'd0,
    REG_TYPE_BYTE       = 3'd1,
    REG_END_BYTE        = 3'd2,
    REG_MAX_FRAME_BYTES = 3'd3,
    REG_IDLE_LIMIT      = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CSUM_ERR = 2'd1,
    STATUS_TIMEOUT  = 2'd2
  } status_t;

  typedef enum logic {
    MODE_BYTE = 1'b0,
    MODE_TICK = 1'b1
  } mode_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] temperature;
  } result_t;

endpackage

// ===== rtl/core/serial_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// serial_frame_receiver
// deframes received serial bytes and reports complete frames on poll ticks
// ----------------------------------------------------------------------------
//
//  channel   signals                               direction  transaction
//  --------  ------------------------------------  ---------  ---------------------
//  item      item_valid, item_ready, item          in         one byte or poll tick
//  result    result_valid, result_ready, result    out        frame status + temp
//  cfg       cfg_valid, cfg_ready, cfg_index/data  in         one register write
//
//  one item per cycle: the frame state updates on the accepting edge and any
//  result lands in the result register on that same edge
//  the item side stalls only while the result register holds a transaction
//  that the sink does not take in the same cycle
//  cfg writes are always taken, cfg_ready is tied high
//  reset is synchronous and clears all frame state, registers go to defaults
//
module serial_frame_receiver
  import sfr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // item channel
  input  logic                   item_valid,
  output logic                   item_ready,
  input  item_t                  item,
  // result channel
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [8:0]             cfg_data
);

  // configuration registers
  logic [7:0] start_byte;
  logic [7:0] type_byte;
  logic [7:0] end_byte;
  logic [8:0] max_frame_bytes;
  logic [7:0] idle_limit;

  // frame state
  logic [8:0] byte_count,   byte_count_next;
  logic [7:0] running_xor,  running_xor_next;
  logic [7:0] length_field, length_field_next;
  logic [7:0] temp_high,    temp_high_next;
  logic [7:0] temp_low,     temp_low_next;
  logic       frame_ready,  frame_ready_next;
  logic [7:0] idle_ticks,   idle_ticks_next;

  // result staging
  logic       item_fire;
  logic       res_load;
  result_t    res_data;

  // datapath helpers
  logic [7:0] b;
  logic [7:0] len_eff;
  logic [8:0] total;
  logic [8:0] count_inc;

  assign cfg_ready  = 1'b1;
  // the result register frees up in the same cycle it is drained
  assign item_ready = !result_valid || result_ready;
  assign item_fire  = item_valid && item_ready;

  assign b         = item.rx_byte;
  // length byte is used in the same cycle it arrives
  assign len_eff   = (byte_count == 9'd2) ? b : length_field;
  assign total     = {1'b0, len_eff} + FRAME_OVERHEAD;
  assign count_inc = byte_count + 9'd1;

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte      <= START_BYTE_RST;
      type_byte       <= TYPE_BYTE_RST;
      end_byte        <= END_BYTE_RST;
      max_frame_bytes <= MAX_FRAME_BYTES_RST;
      idle_limit      <= IDLE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_START_BYTE:      start_byte      <= cfg_data[7:0];
        REG_TYPE_BYTE:       type_byte       <= cfg_data[7:0];
        REG_END_BYTE:        end_byte        <= cfg_data[7:0];
        REG_MAX_FRAME_BYTES: max_frame_bytes <= cfg_data;
        REG_IDLE_LIMIT:      idle_limit      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // next frame state and result for the accepted item
  always_comb begin
    byte_count_next   = byte_count;
    running_xor_next  = running_xor;
    length_field_next = length_field;
    temp_high_next    = temp_high;
    temp_low_next     = temp_low;
    frame_ready_next  = frame_ready;
    idle_ticks_next   = idle_ticks;
    res_load          = 1'b0;
    res_data          = '{status: STATUS_OK, temperature: 16'd0};

    if (item_fire) begin
      if (mode_t'(item.mode) == MODE_BYTE) begin
        // any received byte counts as line activity
        idle_ticks_next = 8'd0;
        // while a finished frame waits, bytes are dropped
        if (!frame_ready) begin
          if (byte_count == 9'd0) begin
            // hunt for the start byte
            if (b == start_byte) begin
              running_xor_next = b;
              byte_count_next  = 9'd1;
            end
          end else if (byte_count == 9'd1) begin
            // type check, a bad type throws the frame away
            if (b != type_byte) begin
              byte_count_next  = 9'd0;
              running_xor_next = 8'd0;
            end else begin
              running_xor_next = running_xor ^ b;
              byte_count_next  = 9'd2;
            end
          end else begin
            // capture length and the two temperature bytes
            if (byte_count == 9'd2) begin
              length_field_next = b;
            end else if (byte_count == 9'd3) begin
              temp_high_next = b;
            end else if (byte_count == 9'd4) begin
              temp_low_next = b;
            end
            if (total > max_frame_bytes) begin
              // oversize frame, checked on every byte
              byte_count_next  = 9'd0;
              running_xor_next = 8'd0;
            end else if (total == count_inc) begin
              // last byte must be the end marker
              if (b == end_byte) begin
                frame_ready_next = 1'b1;
                byte_count_next  = count_inc;
              end else begin
                byte_count_next  = 9'd0;
                running_xor_next = 8'd0;
              end
            end else begin
              byte_count_next  = count_inc;
              running_xor_next = running_xor ^ b;
            end
          end
        end
      end else begin
        // poll tick
        if (frame_ready) begin
          // report and release the waiting frame either way
          res_load = 1'b1;
          if (running_xor == 8'd0) begin
            res_data = '{status: STATUS_OK, temperature: {temp_high, temp_low}};
          end else begin
            res_data = '{status: STATUS_CSUM_ERR, temperature: 16'd0};
          end
          frame_ready_next = 1'b0;
          byte_count_next  = 9'd0;
          running_xor_next = 8'd0;
        end else if (byte_count != 9'd0) begin
          if (idle_ticks > idle_limit) begin
            // stale partial frame
            res_load         = 1'b1;
            res_data         = '{status: STATUS_TIMEOUT, temperature: 16'd0};
            byte_count_next  = 9'd0;
            running_xor_next = 8'd0;
            idle_ticks_next  = 8'd0;
          end else if (idle_ticks != IDLE_TICKS_MAX) begin
            idle_ticks_next = idle_ticks + 8'd1;
          end
        end
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= 9'd0;
      running_xor  <= 8'd0;
      length_field <= 8'd0;
      temp_high    <= 8'd0;
      temp_low     <= 8'd0;
      frame_ready  <= 1'b0;
      idle_ticks   <= 8'd0;
    end else begin
      byte_count   <= byte_count_next;
      running_xor  <= running_xor_next;
      length_field <= length_field_next;
      temp_high    <= temp_high_next;
      temp_low     <= temp_low_next;
      frame_ready  <= frame_ready_next;
      idle_ticks   <= idle_ticks_next;
    end
  end

  // result register, valid is control state, payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res_data;
    end
  end

endmodule

// ===== rtl/core/sfr_checker.sv =====
// ----------------------------------------------------------------------------
// sfr_checker
// port level checks of the serial frame receiver
// ----------------------------------------------------------------------------
module sfr_checker
  import sfr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_ready,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  result_t                result
);

  // reset leaves no transaction pending
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // only the three defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == STATUS_OK || result.status == STATUS_CSUM_ERR ||
                      result.status == STATUS_TIMEOUT))
    else $error("undefined status code");

  // failed frames carry no temperature
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != STATUS_OK |-> result.temperature == 16'd0)
    else $error("temperature on failed frame");

  // a full result register that is not drained blocks items
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !item_ready)
    else $error("item taken while result stalled");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (.*);

// ===== sim/tb_serial_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_frame_receiver
// self-checking bench for the serial frame receiver: a frame decoder model
// tracks each byte and tick the block takes and predicts every frame report;
// directed frames hit the corner cases, then random frame streams run under
// several register settings with bursty input and a stalling result sink
// ----------------------------------------------------------------------------
module tb_serial_frame_receiver;
  import sfr_pkg::*;

  localparam int unsigned TIMEOUT_NS   = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 4;
  // index past the end of the register map, writes are dropped
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  // clock, reset and dut ports
  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   item_valid   = 1'b0;
  logic                   item_ready;
  item_t                  item         = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [8:0]             cfg_data     = '0;

  // register mirror, follows every accepted cfg write
  logic [7:0] cfg_start = START_BYTE_RST;
  logic [7:0] cfg_type  = TYPE_BYTE_RST;
  logic [7:0] cfg_end   = END_BYTE_RST;
  logic [8:0] cfg_max   = MAX_FRAME_BYTES_RST;
  logic [7:0] cfg_idle  = IDLE_LIMIT_RST;

  // frame decoder model state
  logic [8:0] rx_count   = '0;
  logic [7:0] rx_xor     = '0;
  logic [7:0] len_q      = '0;
  logic [7:0] temp_hi    = '0;
  logic [7:0] temp_lo    = '0;
  logic       frame_done = 1'b0;
  logic [7:0] idle_cnt   = '0;

  // bytes and ticks waiting to be sent, and frame reports still owed
  item_t       rx_stream[$];
  result_t     expected_reports[$];
  int unsigned stream_len  = 0;
  int unsigned items_taken = 0;
  int unsigned reports_seen = 0;
  int unsigned error_count = 0;

  // sender burst shaping
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  // sink stall shaping
  logic [15:0] stall_cyc     = '0;
  int unsigned holdoff_left  = 0;
  int unsigned holdoffs_done = 0;

  always #2 clk = ~clk;

  serial_frame_receiver dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // frame decoder model: advance on one accepted byte or tick, queue any report
  // --------------------------------------------------------------------------
  task automatic deframe_item(input item_t it);
    logic [8:0] total;
    result_t    r;
    if (it.mode == MODE_BYTE) begin
      // any byte ends an idle stretch
      idle_cnt = '0;
      if (frame_done) begin
        // a finished frame holds off all bytes until the next tick
      end else if (rx_count == 9'd0) begin
        if (it.rx_byte == cfg_start) begin
          rx_xor   = it.rx_byte;
          rx_count = 9'd1;
        end
      end else if (rx_count == 9'd1) begin
        // wrong type restarts, and the byte is not reused as a start
        if (it.rx_byte != cfg_type) begin
          rx_count = '0;
          rx_xor   = '0;
        end else begin
          rx_xor   = rx_xor ^ it.rx_byte;
          rx_count = 9'd2;
        end
      end else begin
        case (rx_count)
          9'd2: len_q   = it.rx_byte;
          9'd3: temp_hi = it.rx_byte;
          9'd4: temp_lo = it.rx_byte;
          default: ;
        endcase
        rx_count = rx_count + 9'd1;
        total    = {1'b0, len_q} + FRAME_OVERHEAD;
        // length is rechecked on every byte, so a lowered limit bites mid-frame
        if (total > cfg_max) begin
          rx_count = '0;
          rx_xor   = '0;
        end else if (total == rx_count) begin
          if (it.rx_byte == cfg_end) begin
            frame_done = 1'b1;
          end else begin
            rx_count = '0;
            rx_xor   = '0;
          end
        end else begin
          rx_xor = rx_xor ^ it.rx_byte;
        end
      end
    end else if (frame_done) begin
      // waiting frame goes out on the tick, good checksum or not
      if (rx_xor == 8'd0) begin
        r.status      = STATUS_OK;
        r.temperature = {temp_hi, temp_lo};
      end else begin
        r.status      = STATUS_CSUM_ERR;
        r.temperature = '0;
      end
      expected_reports.push_back(r);
      frame_done = 1'b0;
      rx_count   = '0;
      rx_xor     = '0;
    end else if (rx_count != 9'd0) begin
      if (idle_cnt > cfg_idle) begin
        // partial frame idle too long
        r.status      = STATUS_TIMEOUT;
        r.temperature = '0;
        expected_reports.push_back(r);
        rx_count = '0;
        rx_xor   = '0;
        idle_cnt = '0;
      end else if (idle_cnt != IDLE_TICKS_MAX) begin
        idle_cnt = idle_cnt + 8'd1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus building blocks
  // --------------------------------------------------------------------------
  task automatic push_item(input mode_t m, input logic [7:0] b);
    item_t it;
    it.mode    = m;
    it.rx_byte = b;
    rx_stream.push_back(it);
    stream_len++;
  endtask

  // rx_byte is don't-care on ticks, keep it random so every bit toggles
  task automatic push_tick();
    push_item(MODE_TICK, 8'($urandom));
  endtask

  // whole frame at the current register settings
  task automatic push_frame(input int unsigned len, input bit bad_sum, input bit bad_end);
    logic [7:0] sum;
    logic [7:0] b;
    sum = cfg_start ^ cfg_type ^ len[7:0];
    push_item(MODE_BYTE, cfg_start);
    push_item(MODE_BYTE, cfg_type);
    push_item(MODE_BYTE, len[7:0]);
    repeat (len) begin
      b   = 8'($urandom);
      sum = sum ^ b;
      push_item(MODE_BYTE, b);
    end
    if (bad_sum) begin
      sum = sum ^ 8'($urandom_range(1, 255));
    end
    push_item(MODE_BYTE, sum);
    push_item(MODE_BYTE, bad_end ? cfg_end ^ 8'($urandom_range(1, 255)) : cfg_end);
  endtask

  // mostly well formed frames, the rest broken frames, stale partials and noise
  task automatic run_random(input int unsigned n);
    int unsigned goal;
    int unsigned sel;
    int unsigned len;
    int unsigned max_len;
    int unsigned lo;
    logic [7:0]  b;
    goal    = stream_len + n;
    max_len = (cfg_max < 9'd5) ? 0 : (cfg_max > 9'd260) ? 255 : int'(cfg_max) - 5;
    while (stream_len < goal) begin
      sel = $urandom_range(0, 99);
      // short payloads most of the time, now and then anything that fits
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, max_len)
                                         : $urandom_range(0, (max_len < 6) ? max_len : 6);
      if (sel < 78) begin
        push_frame(len, sel >= 60 && sel < 70, sel >= 70);
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 3)) push_item(MODE_BYTE, 8'($urandom));
        end
        repeat (($urandom_range(0, 9) == 0) ? 2 : 1) push_tick();
      end else if (sel < 84) begin
        b = 8'($urandom);
        if (b == cfg_type) begin
          b = ~b;
        end
        push_item(MODE_BYTE, cfg_start);
        push_item(MODE_BYTE, b);
        push_tick();
      end else if (sel < 88 && cfg_max < 9'd260) begin
        lo = (cfg_max < 9'd5) ? 0 : int'(cfg_max) - 4;
        push_item(MODE_BYTE, cfg_start);
        push_item(MODE_BYTE, cfg_type);
        push_item(MODE_BYTE, 8'($urandom_range(lo, 255)));
        repeat ($urandom_range(0, 2)) push_item(MODE_BYTE, 8'($urandom));
        push_tick();
      end else if (sel < 93 && cfg_idle < 8'd64) begin
        // partial frame left alone until it times out
        push_item(MODE_BYTE, cfg_start);
        push_item(MODE_BYTE, cfg_type);
        push_item(MODE_BYTE, len[7:0]);
        if ($urandom_range(0, 1) == 0) begin
          push_item(MODE_BYTE, 8'($urandom));
        end
        repeat (int'(cfg_idle) + 2) push_tick();
      end else if ($urandom_range(0, 1) == 0) begin
        push_tick();
      end else begin
        push_item(MODE_BYTE, ($urandom_range(0, 3) == 0) ? cfg_start : 8'($urandom));
      end
    end
  endtask

  // one register write; cfg_valid stays up for back to back writes
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_START_BYTE:      cfg_start = val[7:0];
      REG_TYPE_BYTE:       cfg_type  = val[7:0];
      REG_END_BYTE:        cfg_end   = val[7:0];
      REG_MAX_FRAME_BYTES: cfg_max   = val;
      REG_IDLE_LIMIT:      cfg_idle  = val[7:0];
      default: ;
    endcase
  endtask

  // all queued items taken and every owed report seen, then a short pause
  task automatic settle();
    do @(posedge clk); while (items_taken != stream_len || expected_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // item driver: bursts of random length separated by random gaps
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      // transaction accepted on this edge, feed the model
      if (item_valid && item_ready) begin
        deframe_item(item);
        items_taken++;
      end
      // slot is free: either nothing was offered or it just went in
      if (!item_valid || item_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (rx_stream.size() != 0) begin
          item       <= rx_stream.pop_front();
          item_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: check each report, stall on its own pattern
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected report: status %0d, temperature %h",
                 result.status, result.temperature);
          error_count++;
        end else begin
          want = expected_reports.pop_front();
          reports_seen++;
          if (result.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, result.status);
            error_count++;
          end
          if (result.temperature !== want.temperature) begin
            $error("temperature mismatch: expected %h, actual %h",
                   want.temperature, result.temperature);
            error_count++;
          end
        end
      end
      // long hold-off while plenty of input is queued so the block backs up
      if (holdoff_left != 0) begin
        holdoff_left--;
        result_ready <= 1'b0;
      end else if (holdoffs_done < 3 && reports_seen >= 10 * (holdoffs_done + 1) &&
                   rx_stream.size() > 40) begin
        holdoff_left = 400;
        holdoffs_done++;
        result_ready <= 1'b0;
      end else begin
        // stall style is picked by bits 9:8 of the free-running stall counter
        case (stall_cyc[9:8])
          2'd0: result_ready <= 1'b1;
          2'd1: result_ready <= ($urandom_range(0, 2) != 0);
          2'd2: result_ready <= (stall_cyc[2:0] >= 3'd3);
          default: result_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
      stall_cyc <= stall_cyc + 16'd1;
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings, directed corner cases first
    push_item(MODE_TICK, 8'hff);               // tick with nothing received
    push_item(MODE_BYTE, 8'h00);               // not a start byte, dropped
    push_item(MODE_BYTE, cfg_start);           // start in the type slot restarts
    push_item(MODE_BYTE, cfg_start);
    push_frame(0, 1'b0, 1'b0);                 // empty payload, checksum and end in temp
    push_tick();
    push_frame(0, 1'b1, 1'b0);                 // bad checksum
    push_item(MODE_BYTE, cfg_start);           // ignored while the frame waits
    push_tick();
    push_frame(0, 1'b0, 1'b1);                 // missing end byte
    push_item(MODE_BYTE, cfg_start);           // oversize length
    push_item(MODE_BYTE, cfg_type);
    push_item(MODE_BYTE, 8'hff);
    push_tick();
    run_random(150);
    settle();

    // low extremes, only empty payloads fit, shortest timeout
    write_reg(REG_START_BYTE, 9'h000);
    write_reg(REG_TYPE_BYTE, 9'h0ff);
    write_reg(REG_END_BYTE, 9'h000);
    write_reg(REG_MAX_FRAME_BYTES, 9'd5);
    write_reg(REG_IDLE_LIMIT, 9'd0);
    cfg_valid <= 1'b0;
    run_random(40);
    settle();

    // high extremes
    write_reg(REG_START_BYTE, 9'h0ff);
    write_reg(REG_TYPE_BYTE, 9'h000);
    write_reg(REG_END_BYTE, 9'h0ff);
    write_reg(REG_MAX_FRAME_BYTES, 9'd260);
    write_reg(REG_IDLE_LIMIT, 9'd255);
    cfg_valid <= 1'b0;
    // idle counter saturates and never passes the top limit
    push_item(MODE_BYTE, cfg_start);
    push_item(MODE_BYTE, cfg_type);
    push_item(MODE_BYTE, 8'd20);
    push_item(MODE_BYTE, 8'($urandom));
    repeat (260) push_tick();
    settle();
    // one below saturation, next tick drops the partial frame
    write_reg(REG_IDLE_LIMIT, 9'd254);
    cfg_valid <= 1'b0;
    push_tick();
    push_frame(60, 1'b0, 1'b0);                // long payload, past the reset limit
    push_tick();
    // limit lowered in the middle of a frame
    push_item(MODE_BYTE, cfg_start);
    push_item(MODE_BYTE, cfg_type);
    push_item(MODE_BYTE, 8'd10);
    push_item(MODE_BYTE, 8'($urandom));
    settle();
    write_reg(REG_MAX_FRAME_BYTES, 9'd10);
    cfg_valid <= 1'b0;
    push_item(MODE_BYTE, 8'($urandom));
    push_tick();
    settle();
    write_reg(REG_MAX_FRAME_BYTES, 9'd260);
    cfg_valid <= 1'b0;
    run_random(30);
    settle();

    // random settings, the middle one with type equal to start
    for (int p = 0; p < 3; p++) begin
      write_reg(REG_START_BYTE, 9'($urandom_range(0, 255)));
      write_reg(REG_TYPE_BYTE, (p == 1) ? {1'b0, cfg_start} : 9'($urandom_range(0, 255)));
      write_reg(REG_END_BYTE, 9'($urandom_range(0, 255)));
      write_reg(REG_MAX_FRAME_BYTES, 9'($urandom_range(5, 40)));
      write_reg(REG_IDLE_LIMIT, 9'($urandom_range(0, 8)));
      cfg_valid <= 1'b0;
      run_random(15);
      settle();
    end

    // limit below the overhead rejects everything; unmapped write is dropped
    write_reg(REG_MAX_FRAME_BYTES, 9'd0);
    write_reg(REG_UNUSED, 9'h1ff);
    cfg_valid <= 1'b0;
    run_random(15);
    settle();
    write_reg(REG_MAX_FRAME_BYTES, 9'h1ff);
    write_reg(REG_IDLE_LIMIT, 9'($urandom_range(0, 8)));
    cfg_valid <= 1'b0;
    run_random(15);
    settle();

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_serial_frame_receiver: PASS");
    end else begin
      $display("tb_serial_frame_receiver: FAIL");
    end
    $finish;
  end

  // hard stop if the handshakes hang
  initial begin
    #(TIMEOUT_NS);
    $display("tb_serial_frame_receiver: FAIL");
    $finish;
  end

endmodule

// ===== serial_frame_receiver.f =====
rtl/core/sfr_pkg.sv
rtl/core/serial_frame_receiver.sv
rtl/core/sfr_checker.sv
sim/tb_serial_frame_receiver.sv
